// File: rtl/bc45_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bc45_pkg;

	localparam int unsigned TexelsPerBlock = 16;
	localparam logic [3:0] LAST_POS = 4'(TexelsPerBlock - 1);

	// 255^2, the squared length of a unit normal in this fixed-point form
	localparam logic [16:0] RAD_FULL = 17'd65025;

	// reciprocals scaled by 2^16, slightly high so the floor stays exact up to 7*255
	localparam logic [13:0] RECIP7 = 14'd9363;
	localparam logic [13:0] RECIP5 = 14'd13108;

	typedef enum logic [2:0] {
		PAL_RAW,
		PAL_DIV7,
		PAL_DIV5,
		PAL_ZERO,
		PAL_FULL
	} pal_sel_t;

	// one palette entry, split into a weighted sum and the final operation
	typedef struct packed {
		pal_sel_t    sel;
		logic [10:0] num;
	} pal_term_t;

	// per-texel tag that rides along with the data
	typedef struct packed {
		logic [1:0] col;
		logic [1:0] row;
		logic       last;
		logic       bc5;
	} tex_tag_t;

	// partial square root: remainder and root so far
	typedef struct packed {
		logic [9:0] rem;
		logic [7:0] root;
	} sqrt_acc_t;

	function automatic logic [2:0] texel_index(input logic [63:0] blk, input logic [3:0] pos);
		logic [47:0] field;
		field = blk[63:16];
		return field[6'(pos * 3) +: 3];
	endfunction

	// pick the palette entry by index and form its weighted sum
	function automatic pal_term_t pal_term(input logic [7:0] e0, input logic [7:0] e1,
			input logic [2:0] idx);
		pal_term_t  t;
		logic       seven;
		logic [2:0] k;
		logic [2:0] w0;
		seven = (e0 > e1);
		k     = idx - 3'd1;
		w0    = (seven ? 3'd7 : 3'd5) - k;
		t.num = (11'(w0) * 11'(e0)) + (11'(k) * 11'(e1));
		if (idx == 3'd0) begin
			t.sel = PAL_RAW;
			t.num = 11'(e0);
		end else if (idx == 3'd1) begin
			t.sel = PAL_RAW;
			t.num = 11'(e1);
		end else if (seven) begin
			t.sel = PAL_DIV7;
		end else if (idx == 3'd6) begin
			t.sel = PAL_ZERO;
		end else if (idx == 3'd7) begin
			t.sel = PAL_FULL;
		end else begin
			t.sel = PAL_DIV5;
		end
		return t;
	endfunction

	// divide by 7 or 5 (truncating, via a scaled reciprocal), else raw, 0 or 255
	function automatic logic [7:0] pal_value(input pal_term_t t);
		logic [24:0] prod7;
		logic [24:0] prod5;
		logic [7:0]  v;
		prod7 = 25'(t.num) * 25'(RECIP7);
		prod5 = 25'(t.num) * 25'(RECIP5);
		unique case (t.sel)
			PAL_RAW:  v = t.num[7:0];
			PAL_DIV7: v = prod7[23:16];
			PAL_DIV5: v = prod5[23:16];
			PAL_ZERO: v = 8'd0;
			PAL_FULL: v = 8'd255;
			default:  v = 8'd0;
		endcase
		return v;
	endfunction

	// |2v - 255| for an 8-bit v
	function automatic logic [7:0] center_dist(input logic [7:0] v);
		return v[7] ? {v[6:0], 1'b1} : {~v[6:0], 1'b1};
	endfunction

	// one restoring square-root digit
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
		sqrt_acc_t  n;
		logic [9:0] rem_sh;
		logic [9:0] trial;
		rem_sh = {a.rem[7:0], pair};
		trial  = {1'b0, a.root[6:0], 2'b01};
		if (rem_sh >= trial) begin
			n.rem  = rem_sh - trial;
			n.root = {a.root[6:0], 1'b1};
		end else begin
			n.rem  = rem_sh;
			n.root = {a.root[6:0], 1'b0};
		end
		return n;
	endfunction

	function automatic sqrt_acc_t sqrt_step2(input sqrt_acc_t a, input logic [3:0] bits);
		return sqrt_step(sqrt_step(a, bits[3:2]), bits[1:0]);
	endfunction

endpackage

`default_nettype wire

// File: rtl/bc4_bc5_block_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// BC4/BC5 unorm block decoder. Each input item is one compressed 4x4 block
// (a red sub-block and, in BC5 mode, a green sub-block); it yields sixteen
// texels in raster order, one per cycle unless out_stall holds them back,
// with last_texel on the sixteenth. The block is held in an issue register
// and a 4-bit texel counter walks it; the next block is accepted in the
// same cycle the sixteenth texel is issued, so blocks stream with no gap.
// Each texel then passes index select, palette weighted sum, reciprocal
// divide, squares, radicand, four square root stages of two digits each,
// and the output register. channel_mode picks BC4 (r = g = b) or BC5 (b is
// the rebuilt normal Z, computed as (isqrt(65025 - (2r-255)^2 - (2g-255)^2)
// + 255) >> 1); write it only while the block is idle. While out_valid is
// high, out_stall freezes the whole pipeline and backs up into in_stall in
// the same cycle.

module bc4_bc5_block_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] red_block,
	input  wire logic [63:0] green_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       texel_col,
	output logic [1:0]       texel_row,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic             last_texel
);

	// config and issue stage
	logic        mode_q;
	logic        hold_valid_q;
	logic [3:0]  cnt_q;
	logic [63:0] red_q;
	logic [63:0] green_q;

	// pipeline advances whenever the output register is empty or being taken
	logic adv;
	logic accept;

	assign adv    = !out_valid || !out_stall;
	assign in_stall = hold_valid_q && !(adv && (cnt_q == bc45_pkg::LAST_POS));
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			mode_q <= cfg_write_data;
		end
	end

	// counter wraps to zero after the sixteenth texel, so a new block starts at 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (adv && hold_valid_q) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (accept) begin
				hold_valid_q <= 1'b1;
			end else if (adv && (cnt_q == bc45_pkg::LAST_POS)) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_q   <= red_block;
			green_q <= green_block;
		end
	end

	// stage valids
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= hold_valid_q;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// s1: texel indices and endpoints
	bc45_pkg::tex_tag_t tag_s1;
	logic [2:0]         r_idx_s1, g_idx_s1;
	logic [7:0]         r_e0_s1, r_e1_s1, g_e0_s1, g_e1_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.col  <= cnt_q[1:0];
			tag_s1.row  <= cnt_q[3:2];
			tag_s1.last <= (cnt_q == bc45_pkg::LAST_POS);
			tag_s1.bc5  <= mode_q;
			r_idx_s1    <= bc45_pkg::texel_index(red_q, cnt_q);
			g_idx_s1    <= bc45_pkg::texel_index(green_q, cnt_q);
			r_e0_s1     <= red_q[7:0];
			r_e1_s1     <= red_q[15:8];
			g_e0_s1     <= green_q[7:0];
			g_e1_s1     <= green_q[15:8];
		end
	end

	// s2: weighted sum of the chosen palette entry
	bc45_pkg::tex_tag_t  tag_s2;
	bc45_pkg::pal_term_t r_term_s2, g_term_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2    <= tag_s1;
			r_term_s2 <= bc45_pkg::pal_term(r_e0_s1, r_e1_s1, r_idx_s1);
			g_term_s2 <= bc45_pkg::pal_term(g_e0_s1, g_e1_s1, g_idx_s1);
		end
	end

	// s3: divide, and in bc4 mode green follows red
	bc45_pkg::tex_tag_t tag_s3;
	logic [7:0]         r_s3, g_s3;
	logic [7:0]         r_val, g_val;

	assign r_val = bc45_pkg::pal_value(r_term_s2);
	assign g_val = bc45_pkg::pal_value(g_term_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3 <= tag_s2;
			r_s3   <= r_val;
			g_s3   <= tag_s2.bc5 ? g_val : r_val;
		end
	end

	// s4: squared distances from the center
	bc45_pkg::tex_tag_t tag_s4;
	logic [7:0]         r_s4, g_s4;
	logic [15:0]        sqx_s4, sqy_s4;
	logic [7:0]         dx, dy;

	assign dx = bc45_pkg::center_dist(r_s3);
	assign dy = bc45_pkg::center_dist(g_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4 <= tag_s3;
			r_s4   <= r_s3;
			g_s4   <= g_s3;
			sqx_s4 <= 16'(dx) * 16'(dx);
			sqy_s4 <= 16'(dy) * 16'(dy);
		end
	end

	// s5: radicand, clamped at zero
	bc45_pkg::tex_tag_t tag_s5;
	logic [7:0]         r_s5, g_s5;
	logic [15:0]        rad_s5;
	logic [16:0]        sq_sum;
	logic [16:0]        rad_diff;

	assign sq_sum   = 17'(sqx_s4) + 17'(sqy_s4);
	assign rad_diff = bc45_pkg::RAD_FULL - sq_sum;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5 <= tag_s4;
			r_s5   <= r_s4;
			g_s5   <= g_s4;
			rad_s5 <= (sq_sum > bc45_pkg::RAD_FULL) ? 16'd0 : rad_diff[15:0];
		end
	end

	// s6..s9: square root, two digits per stage, high digits first
	bc45_pkg::tex_tag_t  tag_s6, tag_s7, tag_s8, tag_s9;
	logic [7:0]          r_s6, g_s6, r_s7, g_s7, r_s8, g_s8, r_s9, g_s9;
	logic [11:0]         rad_s6;
	logic [7:0]          rad_s7;
	logic [3:0]          rad_s8;
	bc45_pkg::sqrt_acc_t acc_s6, acc_s7, acc_s8, acc_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s6 <= tag_s5;
			r_s6   <= r_s5;
			g_s6   <= g_s5;
			rad_s6 <= rad_s5[11:0];
			acc_s6 <= bc45_pkg::sqrt_step2('0, rad_s5[15:12]);

			tag_s7 <= tag_s6;
			r_s7   <= r_s6;
			g_s7   <= g_s6;
			rad_s7 <= rad_s6[7:0];
			acc_s7 <= bc45_pkg::sqrt_step2(acc_s6, rad_s6[11:8]);

			tag_s8 <= tag_s7;
			r_s8   <= r_s7;
			g_s8   <= g_s7;
			rad_s8 <= rad_s7[3:0];
			acc_s8 <= bc45_pkg::sqrt_step2(acc_s7, rad_s7[7:4]);

			tag_s9 <= tag_s8;
			r_s9   <= r_s8;
			g_s9   <= g_s8;
			acc_s9 <= bc45_pkg::sqrt_step2(acc_s8, rad_s8);
		end
	end

	// s10: output register, z = (root + 255) / 2 in bc5 mode
	bc45_pkg::tex_tag_t tag_s10;
	logic [7:0]         r_s10, g_s10, b_s10;
	logic [8:0]         z_sum;

	assign z_sum = 9'(acc_s9.root) + 9'd255;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s10 <= tag_s9;
			r_s10   <= r_s9;
			g_s10   <= g_s9;
			b_s10   <= tag_s9.bc5 ? z_sum[8:1] : r_s9;
		end
	end

	assign out_valid  = valid_s10;
	assign texel_col  = tag_s10.col;
	assign texel_row  = tag_s10.row;
	assign last_texel = tag_s10.last;
	assign red_out    = r_s10;
	assign green_out  = g_s10;
	assign blue_out   = b_s10;

endmodule

`default_nettype wire

// File: verif/bc4_bc5_block_decoder_unit_tb.sv
`timescale 1ns / 1ps

module bc4_bc5_block_decoder_unit_tb;

	// the one register: which channel layout the blocks carry
	typedef enum logic {
		MODE_BC4,
		MODE_BC5
	} channel_mode_t;

	// one compressed block as the sender offers it
	typedef struct packed {
		logic [63:0] red;
		logic [63:0] green;
	} block_pair_t;

	// one decoded texel as the receiver should see it
	typedef struct packed {
		logic [1:0] col;
		logic [1:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} texel_t;

	// eight 8-bit palette entries of one sub-block
	typedef logic [7:0][7:0] palette_t;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_PERCENT = 17;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 160;
	localparam int unsigned HOLD_TRIGGER = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic        cfg_write_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] red_block = '0;
	logic [63:0] green_block = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  texel_col;
	logic [1:0]  texel_row;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        last_texel;

	// blocks still to be offered, texels still to arrive
	block_pair_t   pending_blocks[$];
	texel_t        expected_texels[$];

	// shadow of the register, updated only while the block is idle
	channel_mode_t mode_shadow = MODE_BC4;
	// when set, neither side inserts gaps or stalls
	logic          no_gaps = 1'b0;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned texels_seen = 0;
	int unsigned bc4_blocks = 0;
	int unsigned bc5_blocks = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	bc4_bc5_block_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.red_block      (red_block),
		.green_block    (green_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.texel_col      (texel_col),
		.texel_row      (texel_row),
		.red_out        (red_out),
		.green_out      (green_out),
		.blue_out       (blue_out),
		.last_texel     (last_texel)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// palette of one sub-block: both endpoints, then six interpolants when
	// e0 > e1, else four interpolants plus black and white
	function automatic palette_t build_ramp(input logic [63:0] blk);
		palette_t    p;
		int unsigned e0;
		int unsigned e1;
		int unsigned k;
		e0 = blk[7:0];
		e1 = blk[15:8];
		p[0] = 8'(e0);
		p[1] = 8'(e1);
		if (e0 > e1) begin
			for (k = 1; k <= 6; k++)
				p[1 + k] = 8'(((7 - k) * e0 + k * e1) / 7);
		end else begin
			for (k = 1; k <= 4; k++)
				p[1 + k] = 8'(((5 - k) * e0 + k * e1) / 5);
			p[6] = 8'd0;
			p[7] = 8'd255;
		end
		return p;
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic int unsigned floor_sqrt(input int unsigned v);
		int unsigned root;
		int unsigned b;
		root = 0;
		for (b = 128; b != 0; b >>= 1)
			if ((root + b) * (root + b) <= v)
				root += b;
		return root;
	endfunction

	// rebuilt z of a unit normal; the radicand goes negative near the
	// corners (both channels far from mid-scale) and is clamped to zero
	function automatic logic [7:0] normal_z(input logic [7:0] r, input logic [7:0] g);
		int dx;
		int dy;
		int rad;
		dx = 2 * int'(r) - 255;
		dy = 2 * int'(g) - 255;
		rad = 65025 - dx * dx - dy * dy;
		if (rad < 0)
			rad = 0;
		return 8'((floor_sqrt(rad) + 255) >> 1);
	endfunction

	// expected sixteen texels of one accepted block, in raster order
	task automatic decode_block(input block_pair_t blk);
		palette_t   red_ramp;
		palette_t   green_ramp;
		texel_t     t;
		logic [3:0] pos;
		int         i;
		red_ramp = build_ramp(blk.red);
		green_ramp = build_ramp(blk.green);
		for (i = 0; i < bc45_pkg::TexelsPerBlock; i++) begin
			pos = 4'(i);
			t.col = pos[1:0];
			t.row = pos[3:2];
			t.red = red_ramp[blk.red[16 + 3 * i +: 3]];
			if (mode_shadow == MODE_BC5) begin
				t.green = green_ramp[blk.green[16 + 3 * i +: 3]];
				t.blue = normal_z(t.red, t.green);
			end else begin
				// green sub-block plays no part in bc4
				t.green = t.red;
				t.blue = t.red;
			end
			t.last = (i == bc45_pkg::TexelsPerBlock - 1);
			expected_texels.push_back(t);
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			error_count++;
		end
	endtask

	// index field where texel i points at palette entry (i + shift) mod 8
	function automatic logic [47:0] ramp_indices(input int shift);
		logic [47:0] idx;
		int          i;
		for (i = 0; i < bc45_pkg::TexelsPerBlock; i++)
			idx[3 * i +: 3] = 3'(i + shift);
		return idx;
	endfunction

	// random sub-block, biased toward equal and extreme endpoints
	function automatic logic [63:0] random_sub_block();
		logic [63:0] b;
		b = {$urandom, $urandom};
		case ($urandom_range(7))
			0: b[15:8] = b[7:0];
			1: b[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
			2: b[15:8] = $urandom_range(1) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return b;
	endfunction

	// sender: holds an offered block until it is taken, then pulls the
	// next one from the queue unless it decides to idle this cycle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_block('{red: red_block, green: green_block});
				if (mode_shadow == MODE_BC5)
					bc5_blocks++;
				else
					bc4_blocks++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_blocks.size() != 0 &&
						(no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
					in_valid <= 1'b1;
					red_block <= pending_blocks[0].red;
					green_block <= pending_blocks[0].green;
					void'(pending_blocks.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks every taken texel against the oldest expectation,
	// stalls at random, and once holds off long enough to back up the input
	always @(posedge clk) begin
		texel_t t;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				texels_seen++;
				if (expected_texels.size() == 0) begin
					$error("texel with no block pending: col %0d row %0d", texel_col, texel_row);
					error_count++;
				end else begin
					t = expected_texels.pop_front();
					check_field("texel_col", t.col, texel_col);
					check_field("texel_row", t.row, texel_row);
					check_field("red_out", t.red, red_out);
					check_field("green_out", t.green, green_out);
					check_field("blue_out", t.blue, blue_out);
					check_field("last_texel", t.last, last_texel);
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && texels_seen >= HOLD_TRIGGER) begin
				// long hold-off while the sender keeps offering blocks
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
			end else begin
				out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("bc4_bc5_block_decoder_unit: mismatch");
			$finish;
		end
	end

	// wait until every queued block is taken and every texel has come out,
	// then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		while (pending_blocks.size() != 0 || in_valid || expected_texels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic set_mode(input channel_mode_t m);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		mode_shadow = m;
	endtask

	// corner blocks: extreme, equal and adjacent endpoints in both orders,
	// indices sweeping every palette entry, plus all-zero and all-one blocks
	// (the latter two drive the normal-z radicand negative in bc5)
	task automatic queue_corner_blocks();
		logic [15:0] ends [8];
		int          k;
		ends = '{16'h00FF, 16'hFF00, 16'h8080, 16'h0000, 16'hFFFF, 16'h0001,
			16'h07C8, 16'hFFFE};
		for (k = 0; k < 8; k++)
			pending_blocks.push_back('{red: {ramp_indices(k), ends[k]},
				green: {ramp_indices(k + 3), ends[7 - k]}});
		pending_blocks.push_back('{red: '0, green: '0});
		pending_blocks.push_back('{red: '1, green: '1});
	endtask

	task automatic queue_random_blocks(input int count);
		int n;
		for (n = 0; n < count; n++)
			pending_blocks.push_back('{red: random_sub_block(), green: random_sub_block()});
	endtask

	initial begin
		// hold reset, then release it at a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners in each mode
		set_mode(MODE_BC4);
		queue_corner_blocks();
		drain();
		set_mode(MODE_BC5);
		queue_corner_blocks();
		drain();

		// random blocks with gaps; the long receiver hold-off lands here
		set_mode(MODE_BC4);
		queue_random_blocks(120);
		drain();

		// back-to-back stretch with no gaps on either side
		set_mode(MODE_BC5);
		no_gaps = 1'b1;
		queue_random_blocks(130);
		drain();
		no_gaps = 1'b0;

		set_mode(MODE_BC4);
		queue_random_blocks(60);
		drain();
		set_mode(MODE_BC5);
		queue_random_blocks(60);
		drain();

		$display("decoded %0d blocks (%0d bc4, %0d bc5) into %0d texels",
			bc4_blocks + bc5_blocks, bc4_blocks, bc5_blocks, texels_seen);
		$display("both modes, corner endpoints, long output hold-off and gapless streaming");
		if (error_count == 0)
			$display("bc4_bc5_block_decoder_unit: match");
		else
			$display("bc4_bc5_block_decoder_unit: mismatch");
		$finish;
	end

endmodule
